### hdl/assert_macros.svh
// Assertion macros used by the deque top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rbdq_pkg.sv
// Types and constants of the ring buffer deque.
package rbdq_pkg;

  localparam int unsigned DefDepth = 1024;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CountW   = 11;

  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [WordW-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [WordW-1:0] data_out;
    logic [1:0]              status;
    logic [CountW-1:0]       count;
  } res_t;

endpackage

### hdl/rbdq_ram.sv
// Generic single-port synchronous RAM with registered read data.
module rbdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ring_buffer_deque_unit.sv
// Top level of the ring buffer deque: pointers, count and the word store.
// The result strobe comes in the cycle after an accepted request, for every command.
// Throughput: one request per cycle; busy stays low, as each request makes exactly
// one access to the single-port word store and the pointers settle in the same cycle.
// Reset clears the pointers, the count and the result strobe; the word store is not
// cleared, since a pop only ever reads a slot that an earlier push wrote.
module ring_buffer_deque_unit #(
  parameter int unsigned DEPTH = rbdq_pkg::DefDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rbdq_pkg::req_t   req_i,
  output logic             done_o,
  output rbdq_pkg::res_t   res_o
);

  import rbdq_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  // Indices wrap by compare, so DEPTH need not be a power of two.
  function automatic logic [IdxW-1:0] wrap_next(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] wrap_prev(input logic [IdxW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - 1'b1;
  endfunction

  logic [IdxW-1:0] front_q, front_d;   // slot of the front word
  logic [IdxW-1:0] back_q, back_d;     // slot one past the back word
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  logic            take_rd_q, take_rd_d; // result word comes from the store
  res_t            res_q, res_d;

  logic             accept;
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_addr;
  logic [WordW-1:0] ram_rdata;
  logic             is_empty, is_full;

  assign busy     = 1'b0;
  assign accept   = start & ~busy;
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == FullCnt);

  // One store access per request: write for a push, read for a pop.
  always_comb begin
    front_d          = front_q;
    back_d           = back_q;
    cnt_d            = cnt_q;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_addr         = back_q;
    take_rd_d        = 1'b0;
    res_d.data_out   = '0;
    res_d.status     = ST_DONE;
    if (accept) begin
      unique case (cmd_e'(req_i.command))
        CMD_PUSH_BACK: begin
          if (is_full) begin
            res_d.status = ST_FULL;
          end else begin
            ram_we   = 1'b1;
            ram_addr = back_q;
            back_d   = wrap_next(back_q);
            cnt_d    = cnt_q + 1'b1;
          end
        end
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            res_d.status = ST_FULL;
          end else begin
            ram_we   = 1'b1;
            ram_addr = wrap_prev(front_q);
            front_d  = wrap_prev(front_q);
            cnt_d    = cnt_q + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (is_empty) begin
            res_d.data_out = '1;
            res_d.status   = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            ram_addr  = front_q;
            front_d   = wrap_next(front_q);
            cnt_d     = cnt_q - 1'b1;
            take_rd_d = 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (is_empty) begin
            res_d.data_out = '1;
            res_d.status   = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            ram_addr  = wrap_prev(back_q);
            back_d    = wrap_prev(back_q);
            cnt_d     = cnt_q - 1'b1;
            take_rd_d = 1'b1;
          end
        end
        default: begin
          res_d.status = ST_DONE;
        end
      endcase
    end
    // count is reported after the request, cut or widened to the field
    res_d.count = CountW'(cnt_d);
  end

  rbdq_ram #(
    .Width (WordW),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (req_i.data_in),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      back_q    <= '0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      take_rd_q <= 1'b0;
    end else begin
      front_q   <= front_d;
      back_q    <= back_d;
      cnt_q     <= cnt_d;
      done_q    <= accept;
      take_rd_q <= take_rd_d;
    end
  end

  // result payload needs no reset; it is only looked at under done_o
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Popped word arrives from the store's read register in the strobe cycle.
  always_comb begin
    res_o          = res_q;
    res_o.data_out = take_rd_q ? ram_rdata : res_q.data_out;
  end

  assign done_o = done_q;

  `ASSERT_CLK_RST(a_done_follows_req, clk_i, rst_ni, accept |=> done_o,
                  "accepted request gave no result")
  `ASSERT_CLK_RST(a_no_spurious_done, clk_i, rst_ni, !accept |=> !done_o,
                  "result without a request")
  `ASSERT_CLK(a_count_bound, clk_i, (!rst_ni) || (cnt_q <= FullCnt), "count above depth")
  `ASSERT_CLK_RST(a_ptr_meet, clk_i, rst_ni,
                  (cnt_q == '0 || cnt_q == FullCnt) |-> (front_q == back_q),
                  "pointers apart while empty or full")
  `ASSERT_CLK_RST(a_read_only_on_pop, clk_i, rst_ni,
                  take_rd_q |-> (res_q.status == ST_DONE),
                  "store read on a refused request")

endmodule
